@@ hdl/indexed_list_engine_assert.svh @@
`ifndef INDEXED_LIST_ENGINE_ASSERT_SVH
`define INDEXED_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/ile_pkg.sv @@
package ile_pkg;

  localparam int CAPACITY    = 1024;
  localparam int VALUE_WIDTH = 16;

  localparam int KIND_W = 3;
  localparam int POS_W  = 11;
  localparam int ITEM_W = 16;
  localparam int RDV_W  = 16;
  localparam int STAT_W = 2;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GROUP = 32;
  localparam int NGRP  = (CAPACITY + GROUP - 1) / GROUP;

  localparam logic [KIND_W-1:0] REQ_READ   = 3'd0;
  localparam logic [KIND_W-1:0] REQ_HEAD   = 3'd1;
  localparam logic [KIND_W-1:0] REQ_TAIL   = 3'd2;
  localparam logic [KIND_W-1:0] REQ_BEFORE = 3'd3;
  localparam logic [KIND_W-1:0] REQ_DELETE = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_READ = 2'd1;
  localparam logic [1:0] OP_INS  = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] val_t;

  typedef struct packed {
    logic [KIND_W-1:0] req_type;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_value;
  } req_t;

  typedef struct packed {
    logic [RDV_W-1:0]  read_value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count_now;
  } res_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [CMP_W-1:0] pos;
    val_t             value;
  } cmd_t;

endpackage

@@ hdl/indexed_list_engine.sv @@
// Steps: decode, cell update with group OR, final OR into the output register,
// which waits while a stalled result is held; one request in flight at a time.
// Inserts and deletes shift all cells from the given position upward at once.
// A finished result waits in the output register while the next request runs.
// Reset (rst_n low, synchronous) empties the list; cell contents stay undefined.
module indexed_list_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ile_pkg::req_t in_req,
  output logic          out_valid,
  input  logic          out_stall,
  output ile_pkg::res_t out_res
);
  import ile_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EXEC   = 2'd1;
  localparam logic [1:0] S_REDUCE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  cmd_t              cmd_r, cmd_nxt;
  logic [STAT_W-1:0] st_r, st_nxt;
  val_t              grp_r [NGRP];
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r, out_res_nxt;

  cmd_t  cmd_bus;
  val_t  cell_val [CAPACITY];
  val_t  cell_rd  [CAPACITY];
  val_t  grp_nxt  [NGRP];
  val_t  tree_or;
  logic  in_acc;
  logic  out_free;
  logic  full;
  logic [CMP_W-1:0] len_ext, pos_ext;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign full     = (len_r == CNT_W'(CAPACITY));
  assign len_ext  = CMP_W'(len_r);
  assign pos_ext  = CMP_W'(in_req.position);

  always_comb begin
    cmd_bus = cmd_r;
    if (state_r != S_EXEC) begin
      cmd_bus.op = OP_NONE;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      ile_cell u_cell (
        .clk       (clk),
        .cmd       (cmd_bus),
        .idx       (CMP_W'(gi)),
        .left_val  (cell_val[(gi == 0) ? gi : gi - 1]),
        .right_val (cell_val[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .val_o     (cell_val[gi]),
        .rd_o      (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_nxt[g] = '0;
      for (int k = 0; k < GROUP; k++) begin
        if (g * GROUP + k < CAPACITY) begin
          grp_nxt[g] = grp_nxt[g] | cell_rd[g * GROUP + k];
        end
      end
    end
  end

  always_comb begin
    tree_or = '0;
    for (int g = 0; g < NGRP; g++) begin
      tree_or = tree_or | grp_r[g];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cmd_nxt       = cmd_r;
    st_nxt        = st_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt.op    = OP_NONE;
          cmd_nxt.pos   = pos_ext;
          cmd_nxt.value = VALUE_WIDTH'(in_req.item_value);
          st_nxt        = ST_DONE;
          unique case (in_req.req_type) inside
            REQ_READ: begin
              if (pos_ext < len_ext) begin
                cmd_nxt.op = OP_READ;
              end else begin
                st_nxt = ST_BAD_INDEX;
              end
            end
            REQ_HEAD, REQ_TAIL: begin
              if (full) begin
                st_nxt = ST_FULL;
              end else begin
                cmd_nxt.op  = OP_INS;
                cmd_nxt.pos = (in_req.req_type == REQ_HEAD) ? '0 : len_ext;
              end
            end
            REQ_BEFORE: begin
              if (pos_ext > len_ext) begin
                st_nxt = ST_BAD_INDEX;
              end else if (full) begin
                st_nxt = ST_FULL;
              end else begin
                cmd_nxt.op = OP_INS;
              end
            end
            REQ_DELETE: begin
              if (pos_ext < len_ext) begin
                cmd_nxt.op = OP_DEL;
              end else begin
                st_nxt = ST_BAD_INDEX;
              end
            end
            default: st_nxt = ST_BAD_INDEX;
          endcase
          if (cmd_nxt.op == OP_INS) begin
            len_nxt = len_r + 1'b1;
          end else if (cmd_nxt.op == OP_DEL) begin
            len_nxt = len_r - 1'b1;
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_res_nxt.read_value = RDV_W'(tree_or);
          out_res_nxt.status     = st_r;
          out_res_nxt.count_now  = len_r;
          state_nxt              = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    st_r      <= st_nxt;
    out_res_r <= out_res_nxt;
    if (state_r == S_EXEC) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_nxt[g];
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`include "indexed_list_engine_assert.svh"

  `ILE_ASSERT_NOW(a_len_bound, 1'b1, len_r <= CNT_W'(CAPACITY), "length beyond capacity")
  `ILE_ASSERT_NEXT(a_accept_exec, in_acc, state_r == S_EXEC, "accept did not start execution")
  `ILE_ASSERT_NOW(a_full_count, out_valid_r && out_res_r.status == ST_FULL, out_res_r.count_now == CNT_W'(CAPACITY), "full status with room left")
  `ILE_ASSERT_NOW(a_miss_zero, out_valid_r && out_res_r.status != ST_DONE, out_res_r.read_value == '0, "nonzero value on ignored request")

endmodule

@@ hdl/ile_cell.sv @@
module ile_cell (
  input  logic                     clk,
  input  ile_pkg::cmd_t            cmd,
  input  logic [ile_pkg::CMP_W-1:0] idx,
  input  ile_pkg::val_t            left_val,
  input  ile_pkg::val_t            right_val,
  output ile_pkg::val_t            val_o,
  output ile_pkg::val_t            rd_o
);
  import ile_pkg::*;

  val_t val_r;
  val_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    unique case (cmd.op)
      OP_INS: begin
        if (idx == cmd.pos) begin
          val_nxt = cmd.value;
        end else if (idx > cmd.pos) begin
          val_nxt = left_val;
        end
      end
      OP_DEL: begin
        if (idx >= cmd.pos) begin
          val_nxt = right_val;
        end
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val_o = val_r;
  assign rd_o  = (cmd.op == OP_READ && idx == cmd.pos) ? val_r : '0;

endmodule
